@@ design/tvec_pkg.sv @@
// ----------------------------------------------------------------------------
// tvec_pkg
// shared types and constants of the triangle tangent vector core
// ----------------------------------------------------------------------------
package tvec_pkg;

   // field widths
   localparam int POS_W   = 24;
   localparam int TEX_W   = 16;
   localparam int OUT_W   = 16;

   // normalisation window for the largest tangent magnitude
   localparam int NORM_LO = 23;
   localparam int NORM_HI = 24;

   // derived datapath widths
   localparam int EDGE_W  = POS_W + 1;
   localparam int DT_W    = TEX_W + 1;
   localparam int OPND_W  = (EDGE_W > NORM_HI + 1) ? EDGE_W : NORM_HI + 1;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int TAN_W   = EDGE_W + DT_W + 1;
   localparam int SUM_W   = 2 * NORM_HI + 2;
   localparam int LEN_W   = NORM_HI + 1;
   localparam int FRAC    = 14;
   localparam int QUO_W   = FRAC + 1;
   localparam int REM_W   = LEN_W + QUO_W;

   // sequencer lengths
   localparam int MUL_STEPS  = 14;
   localparam int SQ_STEPS   = 3;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int CNT_W      = 5;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [TEX_W-1:0] tex_u;
      logic signed [TEX_W-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] tan_x;
      logic signed [OUT_W-1:0] tan_y;
      logic signed [OUT_W-1:0] tan_z;
      logic                    flipped;
      logic                    degenerate;
   } rsp_type;

   // operand pairs of the shared multiplier
   typedef enum logic [4:0] {
      MOP_T0A, MOP_T0B, MOP_T1A, MOP_T1B, MOP_T2A, MOP_T2B,
      MOP_N0A, MOP_N0B, MOP_N1A, MOP_N1B, MOP_N2A, MOP_N2B,
      MOP_DETA, MOP_DETB,
      MOP_SQ0, MOP_SQ1, MOP_SQ2
   } mop_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_MUL_WAIT, ST_NORM, ST_SQR, ST_SQR_WAIT,
      ST_SQRT, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic       hold_wr;
      logic       hold_slot;
      logic       capture;
      logic       mul_issue;
      mop_type    mul_idx;
      logic       norm_step;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_last;
      logic [1:0] div_sel;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic norm_ok;
      logic tan_zero;
   } sts_type;

endpackage

@@ design/tvec_datapath.sv @@
// ----------------------------------------------------------------------------
// tvec_datapath
// vertex store, shared multiplier, normaliser, square root and divider
// ----------------------------------------------------------------------------
module tvec_datapath (
   input  logic              clock,
   input  tvec_pkg::req_type req_data,
   input  tvec_pkg::cmd_type cmd,
   output tvec_pkg::sts_type sts,
   output tvec_pkg::rsp_type rsp_data
);

   localparam int TW = tvec_pkg::TAN_W;
   localparam int PW = tvec_pkg::PROD_W;
   localparam int OW = tvec_pkg::OPND_W;
   localparam int EW = tvec_pkg::EDGE_W;
   localparam int DW = tvec_pkg::DT_W;
   localparam int SW = tvec_pkg::SUM_W;
   localparam int RW = tvec_pkg::REM_W;
   localparam int QW = tvec_pkg::QUO_W;
   localparam int NH = tvec_pkg::NORM_HI;
   localparam int NL = tvec_pkg::NORM_LO;
   localparam int LW = tvec_pkg::LEN_W;
   localparam int UW = tvec_pkg::OUT_W;

   localparam logic [TW-1:0] NRM_R8 = TW'(1) << (NH + 8);
   localparam logic [TW-1:0] NRM_R1 = TW'(1) << NH;
   localparam logic [TW-1:0] NRM_L8 = TW'(1) << (NL - 8);
   localparam logic [TW-1:0] NRM_L1 = TW'(1) << NL;
   localparam logic [SW-1:0] SQRT_TOP = SW'(1) << (SW - 2);

   tvec_pkg::req_type held_ff [2];

   logic signed [EW-1:0] s0_ff [3];
   logic signed [EW-1:0] s1_ff [3];
   logic signed [EW-1:0] s0_in [3];
   logic signed [EW-1:0] s1_in [3];
   logic signed [DW-1:0] du0_ff, dv0_ff, du1_ff, dv1_ff;

   logic signed [OW-1:0] opa, opb;
   logic signed [PW-1:0] prod_in, prod_ff, first_ff;
   logic                 prod_vld_ff;
   tvec_pkg::mop_type    prod_idx_ff;
   logic signed [PW:0]   diff;
   logic        [PW:0]   dmag;

   logic [TW-1:0] amag_ff [3];
   logic [2:0]    tneg_ff;
   logic [2:0]    eq_ff;
   logic          detneg_ff;
   logic [SW-1:0] sum_ff;
   logic [TW-1:0] mmax;

   logic [SW-1:0] x_ff, r_ff, sbit_ff;
   logic [SW:0]   rb;
   logic          sq_ge;
   logic [LW-1:0] len;

   logic [RW-1:0] rem_ff, dsor_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [QW-1:0] res_ff [3];
   logic          dv_ge;

   logic                 flip;
   logic                 degen;
   tvec_pkg::rsp_type    rsp_in;
   tvec_pkg::rsp_type    rsp_data_ff;
   logic        [UW-1:0] umag [3];
   logic signed [UW-1:0] tval [3];

   // edges of the triangle
   always_comb begin
      s0_in[0] = EW'(held_ff[0].pos_x) - EW'(held_ff[1].pos_x);
      s0_in[1] = EW'(held_ff[0].pos_y) - EW'(held_ff[1].pos_y);
      s0_in[2] = EW'(held_ff[0].pos_z) - EW'(held_ff[1].pos_z);
      s1_in[0] = EW'(req_data.pos_x) - EW'(held_ff[0].pos_x);
      s1_in[1] = EW'(req_data.pos_y) - EW'(held_ff[0].pos_y);
      s1_in[2] = EW'(req_data.pos_z) - EW'(held_ff[0].pos_z);
   end

   // operand select for the shared multiplier
   always_comb begin
      opa = '0;
      opb = '0;
      case (cmd.mul_idx)
         tvec_pkg::MOP_T0A:  begin opa = OW'(dv1_ff);   opb = OW'(s0_ff[0]); end
         tvec_pkg::MOP_T0B:  begin opa = OW'(dv0_ff);   opb = OW'(s1_ff[0]); end
         tvec_pkg::MOP_T1A:  begin opa = OW'(dv1_ff);   opb = OW'(s0_ff[1]); end
         tvec_pkg::MOP_T1B:  begin opa = OW'(dv0_ff);   opb = OW'(s1_ff[1]); end
         tvec_pkg::MOP_T2A:  begin opa = OW'(dv1_ff);   opb = OW'(s0_ff[2]); end
         tvec_pkg::MOP_T2B:  begin opa = OW'(dv0_ff);   opb = OW'(s1_ff[2]); end
         tvec_pkg::MOP_N0A:  begin opa = OW'(s1_ff[1]); opb = OW'(s0_ff[2]); end
         tvec_pkg::MOP_N0B:  begin opa = OW'(s1_ff[2]); opb = OW'(s0_ff[1]); end
         tvec_pkg::MOP_N1A:  begin opa = OW'(s1_ff[2]); opb = OW'(s0_ff[0]); end
         tvec_pkg::MOP_N1B:  begin opa = OW'(s1_ff[0]); opb = OW'(s0_ff[2]); end
         tvec_pkg::MOP_N2A:  begin opa = OW'(s1_ff[0]); opb = OW'(s0_ff[1]); end
         tvec_pkg::MOP_N2B:  begin opa = OW'(s1_ff[1]); opb = OW'(s0_ff[0]); end
         tvec_pkg::MOP_DETA: begin opa = OW'(dv1_ff);   opb = OW'(du0_ff);   end
         tvec_pkg::MOP_DETB: begin opa = OW'(dv0_ff);   opb = OW'(du1_ff);   end
         tvec_pkg::MOP_SQ0: begin
            opa = OW'(amag_ff[0][NH-1:0]);
            opb = OW'(amag_ff[0][NH-1:0]);
         end
         tvec_pkg::MOP_SQ1: begin
            opa = OW'(amag_ff[1][NH-1:0]);
            opb = OW'(amag_ff[1][NH-1:0]);
         end
         tvec_pkg::MOP_SQ2: begin
            opa = OW'(amag_ff[2][NH-1:0]);
            opb = OW'(amag_ff[2][NH-1:0]);
         end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   assign prod_in = opa * opb;
   assign diff    = (PW+1)'(first_ff) - (PW+1)'(prod_ff);
   assign dmag    = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);

   // largest magnitude
   always_comb begin
      mmax = amag_ff[0];
      if (amag_ff[1] > mmax) mmax = amag_ff[1];
      if (amag_ff[2] > mmax) mmax = amag_ff[2];
   end

   assign sts.tan_zero = (mmax == '0);
   assign sts.norm_ok  = (mmax >= NRM_L1) && (mmax < NRM_R1);

   // square root step
   assign rb    = {1'b0, r_ff} + {1'b0, sbit_ff};
   assign sq_ge = ({1'b0, x_ff} >= rb);
   assign len   = r_ff[LW-1:0];

   // divide step
   assign dv_ge  = (rem_ff >= dsor_ff);
   assign quo_in = {quo_ff[QW-2:0], dv_ge};

   always_ff @(posedge clock) begin
      if (cmd.hold_wr) begin
         held_ff[cmd.hold_slot] <= req_data;
      end
      if (cmd.capture) begin
         s0_ff  <= s0_in;
         s1_ff  <= s1_in;
         du0_ff <= DW'(held_ff[0].tex_u) - DW'(held_ff[1].tex_u);
         dv0_ff <= DW'(held_ff[0].tex_v) - DW'(held_ff[1].tex_v);
         du1_ff <= DW'(req_data.tex_u) - DW'(held_ff[0].tex_u);
         dv1_ff <= DW'(req_data.tex_v) - DW'(held_ff[0].tex_v);
         sum_ff <= '0;
      end

      prod_ff     <= prod_in;
      prod_idx_ff <= cmd.mul_idx;
      prod_vld_ff <= cmd.mul_issue;

      // consume the product of the previous cycle
      if (prod_vld_ff) begin
         case (prod_idx_ff)
            tvec_pkg::MOP_T0A, tvec_pkg::MOP_T1A, tvec_pkg::MOP_T2A,
            tvec_pkg::MOP_N0A, tvec_pkg::MOP_N1A, tvec_pkg::MOP_N2A,
            tvec_pkg::MOP_DETA: first_ff <= prod_ff;
            tvec_pkg::MOP_T0B: begin
               tneg_ff[0] <= diff[PW];
               amag_ff[0] <= dmag[TW-1:0];
            end
            tvec_pkg::MOP_T1B: begin
               tneg_ff[1] <= diff[PW];
               amag_ff[1] <= dmag[TW-1:0];
            end
            tvec_pkg::MOP_T2B: begin
               tneg_ff[2] <= diff[PW];
               amag_ff[2] <= dmag[TW-1:0];
            end
            tvec_pkg::MOP_N0B:  eq_ff[0]  <= (diff == '0);
            tvec_pkg::MOP_N1B:  eq_ff[1]  <= (diff == '0);
            tvec_pkg::MOP_N2B:  eq_ff[2]  <= (diff == '0);
            tvec_pkg::MOP_DETB: detneg_ff <= diff[PW];
            tvec_pkg::MOP_SQ0, tvec_pkg::MOP_SQ1, tvec_pkg::MOP_SQ2:
               sum_ff <= sum_ff + prod_ff[SW-1:0];
            default: first_ff <= first_ff;
         endcase
      end

      // coarse then fine shift into the normalisation window
      if (cmd.norm_step) begin
         for (int i = 0; i < 3; i++) begin
            if (mmax >= NRM_R8)      amag_ff[i] <= amag_ff[i] >> 8;
            else if (mmax >= NRM_R1) amag_ff[i] <= amag_ff[i] >> 1;
            else if (mmax < NRM_L8)  amag_ff[i] <= amag_ff[i] << 8;
            else if (mmax < NRM_L1)  amag_ff[i] <= amag_ff[i] << 1;
         end
      end

      if (cmd.sqrt_init) begin
         x_ff    <= sum_ff;
         r_ff    <= '0;
         sbit_ff <= SQRT_TOP;
      end else if (cmd.sqrt_step) begin
         if (sq_ge) begin
            x_ff <= x_ff - rb[SW-1:0];
            r_ff <= (r_ff >> 1) + sbit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end

      if (cmd.div_init) begin
         rem_ff  <= (RW'(amag_ff[cmd.div_sel][NH-1:0]) << tvec_pkg::FRAC)
                    + RW'(len >> 1);
         dsor_ff <= RW'(len) << tvec_pkg::FRAC;
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         if (dv_ge) rem_ff <= rem_ff - dsor_ff;
         dsor_ff <= dsor_ff >> 1;
         quo_ff  <= quo_in;
         if (cmd.div_last) res_ff[cmd.div_sel] <= quo_in;
      end

      if (cmd.out_load) rsp_data_ff <= rsp_in;
   end

   // sign and flip
   assign degen = sts.tan_zero;
   assign flip  = !(eq_ff[0] && eq_ff[1] && eq_ff[2]) && detneg_ff && !degen;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         umag[i] = degen ? '0 : UW'(res_ff[i]);
         tval[i] = (tneg_ff[i] ^ flip) ? $signed(UW'(-umag[i])) : $signed(umag[i]);
      end
      rsp_in.tan_x      = tval[0];
      rsp_in.tan_y      = tval[1];
      rsp_in.tan_z      = tval[2];
      rsp_in.flipped    = flip;
      rsp_in.degenerate = degen;
   end

   assign rsp_data = rsp_data_ff;

endmodule

@@ design/tvec_control.sv @@
// ----------------------------------------------------------------------------
// tvec_control
// vertex counter and sequencer for the tangent datapath
// ----------------------------------------------------------------------------
module tvec_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tvec_pkg::sts_type sts,
   output tvec_pkg::cmd_type cmd
);

   localparam int CW = tvec_pkg::CNT_W;

   tvec_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    sel_ff, sel_in;
   logic [1:0]    count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != tvec_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      count_in = count_ff;
      case (state_ff)
         tvec_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (count_ff == 2'd2) begin
                  count_in = '0;
                  cnt_in   = '0;
                  state_in = tvec_pkg::ST_MUL;
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
         end
         tvec_pkg::ST_MUL: begin
            if (cnt_ff == CW'(tvec_pkg::MUL_STEPS - 1)) begin
               state_in = tvec_pkg::ST_MUL_WAIT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         tvec_pkg::ST_MUL_WAIT: state_in = tvec_pkg::ST_NORM;
         tvec_pkg::ST_NORM: begin
            if (sts.tan_zero) begin
               state_in = tvec_pkg::ST_OUT;
            end else if (sts.norm_ok) begin
               state_in = tvec_pkg::ST_SQR;
               cnt_in   = '0;
            end
         end
         tvec_pkg::ST_SQR: begin
            if (cnt_ff == CW'(tvec_pkg::SQ_STEPS - 1)) begin
               state_in = tvec_pkg::ST_SQR_WAIT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         tvec_pkg::ST_SQR_WAIT: begin
            state_in = tvec_pkg::ST_SQRT;
            cnt_in   = '0;
         end
         tvec_pkg::ST_SQRT: begin
            if (cnt_ff == CW'(tvec_pkg::SQRT_STEPS)) begin
               state_in = tvec_pkg::ST_DIV;
               cnt_in   = '0;
               sel_in   = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         tvec_pkg::ST_DIV: begin
            if (cnt_ff == CW'(tvec_pkg::QUO_W)) begin
               cnt_in = '0;
               if (sel_ff == 2'd2) state_in = tvec_pkg::ST_OUT;
               else                sel_in   = sel_ff + 2'd1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         tvec_pkg::ST_OUT: begin
            if (out_free) state_in = tvec_pkg::ST_IDLE;
         end
         default: state_in = tvec_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.hold_slot = count_ff[0];
      cmd.div_sel   = sel_ff;
      case (state_ff)
         tvec_pkg::ST_IDLE: begin
            cmd.hold_wr = req_valid && (count_ff != 2'd2);
            cmd.capture = req_valid && (count_ff == 2'd2);
         end
         tvec_pkg::ST_MUL: begin
            cmd.mul_issue = 1'b1;
            cmd.mul_idx   = tvec_pkg::mop_type'(cnt_ff);
         end
         tvec_pkg::ST_NORM: cmd.norm_step = 1'b1;
         tvec_pkg::ST_SQR: begin
            cmd.mul_issue = 1'b1;
            cmd.mul_idx   = tvec_pkg::mop_type'(CW'(tvec_pkg::MOP_SQ0) + cnt_ff);
         end
         tvec_pkg::ST_SQRT: begin
            cmd.sqrt_init = (cnt_ff == '0);
            cmd.sqrt_step = (cnt_ff != '0);
         end
         tvec_pkg::ST_DIV: begin
            cmd.div_init = (cnt_ff == '0);
            cmd.div_step = (cnt_ff != '0);
            cmd.div_last = (cnt_ff == CW'(tvec_pkg::QUO_W));
         end
         tvec_pkg::ST_OUT: cmd.out_load = out_free;
         default: cmd.out_load = 1'b0;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvec_pkg::ST_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/triangle_tangent_vector_core.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_vector_core
// unit tangent of a textured triangle from three vertex words
// ----------------------------------------------------------------------------
// vertex words: the first and second are stored in the held vertex registers
// third vertex: the result word follows the shared multiplier (17 products),
//   the one-step-a-cycle square root (25 steps) and three bit-serial divides
//   (15 quotient bits each)
// throughput: one result word per three vertex words, one triangle at a time
// reset: synchronous, clears sequencer, vertex count and result valid
// ----------------------------------------------------------------------------
module triangle_tangent_vector_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tvec_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tvec_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   tvec_pkg::cmd_type cmd;
   tvec_pkg::sts_type sts;

   // sequencer: vertex count, step counters, output word valid
   tvec_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: held vertices, edges, products, normalise, sqrt, divide
   tvec_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

@@ tb/triangle_tangent_vector_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_vector_core_tb
// self-checking bench for the triangle tangent vector core
// ----------------------------------------------------------------------------
// vertex words go in three to a triangle; the bench works out the unit
// tangent of every third word and compares it as a whole word with what the
// core returns, under random idling on both sides
// ----------------------------------------------------------------------------
module triangle_tangent_vector_core_tb;

   localparam int PW = tvec_pkg::POS_W;
   localparam int TW = tvec_pkg::TEX_W;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tvec_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   tvec_pkg::rsp_type rsp_data;

   triangle_tangent_vector_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // pending vertex words and expected tangent words
   tvec_pkg::req_type vertex_queue[$];
   tvec_pkg::rsp_type tangent_queue[$];

   // idling percentages, changed by the stimulus process
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          send_pause;
   int unsigned hold_off_left;

   int unsigned mismatches;
   int unsigned words_sent;
   int unsigned tangents_seen;
   int unsigned flips_seen;
   int unsigned degens_seen;

   // model state: the two held vertices and the vertex count
   logic signed [PW-1:0] held_pos[2][3];
   logic signed [TW-1:0] held_tex[2][2];
   int unsigned          vert_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned abs64(longint signed x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // returns 1 and fills tan when the vertex closes a triangle
   function automatic bit tangent_of_vertex(input tvec_pkg::req_type w,
                                            output tvec_pkg::rsp_type tan);
      logic signed [PW-1:0] p[3];
      longint signed        s0[3], s1[3], t[3];
      longint signed        du0, dv0, du1, dv1, det;
      longint unsigned      a[3], m, sum, len;
      logic signed [127:0]  c0, c1, c2;
      bit                   n_zero, flip, degen, neg;
      int                   up, down;
      logic [15:0]          q[3];
      p[0] = w.pos_x;
      p[1] = w.pos_y;
      p[2] = w.pos_z;
      tan  = '0;
      if (vert_count < 2) begin
         for (int i = 0; i < 3; i++) held_pos[vert_count][i] = p[i];
         held_tex[vert_count][0] = w.tex_u;
         held_tex[vert_count][1] = w.tex_v;
         vert_count++;
         return 1'b0;
      end
      vert_count = 0;
      for (int i = 0; i < 3; i++) begin
         s0[i] = longint'(held_pos[0][i]) - longint'(held_pos[1][i]);
         s1[i] = longint'(p[i]) - longint'(held_pos[0][i]);
      end
      du0 = longint'(held_tex[0][0]) - longint'(held_tex[1][0]);
      dv0 = longint'(held_tex[0][1]) - longint'(held_tex[1][1]);
      du1 = longint'(w.tex_u) - longint'(held_tex[0][0]);
      dv1 = longint'(w.tex_v) - longint'(held_tex[0][1]);
      for (int i = 0; i < 3; i++) t[i] = dv1 * s0[i] - dv0 * s1[i];
      // face normal components at full width
      c0 = 128'(s1[1]) * 128'(s0[2]) - 128'(s1[2]) * 128'(s0[1]);
      c1 = 128'(s1[2]) * 128'(s0[0]) - 128'(s1[0]) * 128'(s0[2]);
      c2 = 128'(s1[0]) * 128'(s0[1]) - 128'(s1[1]) * 128'(s0[0]);
      n_zero = (c0 == 0) && (c1 == 0) && (c2 == 0);
      det    = dv1 * du0 - dv0 * du1;
      flip   = !n_zero && det < 0;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = abs64(t[i]);
         if (a[i] > m) m = a[i];
      end
      degen = (m == 0);
      if (degen) begin
         flip = 1'b0;
      end else begin
         up   = 0;
         down = 0;
         while ((m >> down) >= (64'd1 << tvec_pkg::NORM_HI)) down++;
         while ((m << up) < (64'd1 << tvec_pkg::NORM_LO)) up++;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            a[i] = (a[i] >> down) << up;
            sum += a[i] * a[i];
         end
         len = int_sqrt(sum);
         for (int i = 0; i < 3; i++) a[i] = (a[i] * 16384 + len / 2) / len;
      end
      for (int i = 0; i < 3; i++) begin
         neg  = (t[i] < 0) != flip;
         q[i] = neg ? 16'(-a[i]) : 16'(a[i]);
      end
      tan.tan_x      = q[0];
      tan.tan_y      = q[1];
      tan.tan_z      = q[2];
      tan.flipped    = flip;
      tan.degenerate = degen;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- driver
   // the model runs when the core takes a word, so the expectation is queued
   // before the result can come back
   always @(posedge clock) begin
      tvec_pkg::rsp_type tan;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            if (tangent_of_vertex(req_data, tan)) tangent_queue.push_back(tan);
            words_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (!send_pause && vertex_queue.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= vertex_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      tvec_pkg::rsp_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            tangents_seen++;
            if (tangent_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected tangent word %p", rsp_data);
            end else begin
               exp_w = tangent_queue.pop_front();
               flips_seen  += exp_w.flipped;
               degens_seen += exp_w.degenerate;
               if (rsp_data !== exp_w) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("tangent mismatch: expected %p, got %p", exp_w, rsp_data);
               end
            end
         end
         // long hold-off counted here, otherwise random stall
         if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            rsp_stall     <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic tvec_pkg::req_type rand_vertex(int unsigned spread);
      tvec_pkg::req_type w;
      logic [31:0]       r;
      r = $urandom();
      w.pos_x = r[PW-1:0];
      r = $urandom();
      w.pos_y = r[PW-1:0];
      r = $urandom();
      w.pos_z = r[PW-1:0];
      r = $urandom();
      w.tex_u = r[TW-1:0];
      r = $urandom();
      w.tex_v = r[TW-1:0];
      // most triangles small in extent so the tangent sits well inside range
      if (spread == 1) begin
         w.pos_x = $signed(w.pos_x) >>> $urandom_range(20);
         w.pos_y = $signed(w.pos_y) >>> $urandom_range(20);
         w.pos_z = $signed(w.pos_z) >>> $urandom_range(20);
         w.tex_u = $signed(w.tex_u) >>> $urandom_range(14);
         w.tex_v = $signed(w.tex_v) >>> $urandom_range(14);
      end
      return w;
   endfunction

   function automatic tvec_pkg::req_type make_vertex(int px, int py, int pz,
                                                     int tu, int tv);
      tvec_pkg::req_type w;
      w.pos_x = PW'(px);
      w.pos_y = PW'(py);
      w.pos_z = PW'(pz);
      w.tex_u = TW'(tu);
      w.tex_v = TW'(tv);
      return w;
   endfunction

   task automatic wait_drained();
      while (vertex_queue.size() > 0 || req_valid || tangent_queue.size() > 0)
         @(posedge clock);
   endtask

   localparam int PMAX = 8388607;
   localparam int PMIN = -8388608;

   // -------------------------------------------------------------- stimulus
   initial begin
      tvec_pkg::req_type w;
      send_idle_pct = 17;
      recv_idle_pct = 73;
      send_pause    = 1'b0;
      hold_off_left = 0;
      mismatches    = 0;
      words_sent    = 0;
      tangents_seen = 0;
      flips_seen    = 0;
      degens_seen   = 0;
      vert_count    = 0;
      reset         = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: ordinary triangle, mirrored one, degenerate tangent,
      // collinear vertices, field extremes, one vertex repeated three times
      vertex_queue.push_back(make_vertex(0, 0, 0, 0, 0));
      vertex_queue.push_back(make_vertex(4096, 0, 0, 4096, 0));
      vertex_queue.push_back(make_vertex(0, 4096, 0, 0, 4096));
      vertex_queue.push_back(make_vertex(0, 0, 0, 0, 0));
      vertex_queue.push_back(make_vertex(4096, 0, 0, 4096, 0));
      vertex_queue.push_back(make_vertex(0, 4096, 0, 0, -4096));
      vertex_queue.push_back(make_vertex(1, 2, 3, 100, 100));
      vertex_queue.push_back(make_vertex(5, 6, 7, 200, 100));
      vertex_queue.push_back(make_vertex(9, 1, 4, 300, 100));
      vertex_queue.push_back(make_vertex(0, 0, 0, 0, 0));
      vertex_queue.push_back(make_vertex(10, 10, 10, 50, 0));
      vertex_queue.push_back(make_vertex(20, 20, 20, 0, 70));
      vertex_queue.push_back(make_vertex(PMAX, PMAX, PMAX, 32767, 32767));
      vertex_queue.push_back(make_vertex(PMIN, PMIN, PMIN, -32768, -32768));
      vertex_queue.push_back(make_vertex(PMAX, PMIN, PMAX, -32768, 32767));
      vertex_queue.push_back(make_vertex(PMIN, PMAX, 0, 32767, -32768));
      vertex_queue.push_back(make_vertex(PMAX, 0, PMIN, -32768, 32767));
      vertex_queue.push_back(make_vertex(0, PMIN, PMAX, 32767, 32767));
      vertex_queue.push_back(make_vertex(7, 7, 7, 5, 5));
      vertex_queue.push_back(make_vertex(7, 7, 7, 5, 5));
      vertex_queue.push_back(make_vertex(7, 7, 7, 5, 5));
      wait_drained();

      // random in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 73;
            recv_idle_pct = 17;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < 480; i++) begin
            w = rand_vertex(($urandom_range(9) < 7) ? 1 : 0);
            // occasional exact repeats and zero texture deltas
            if ($urandom_range(19) == 0 && vertex_queue.size() > 0)
               w = vertex_queue[$];
            vertex_queue.push_back(w);
         end
         if (ph == 0) begin
            // receiver holds off while words keep coming in
            hold_off_left = 600;
         end
         wait_drained();
         // sender pauses with nothing outstanding
         send_pause = 1'b1;
         repeat ($urandom_range(20, 40)) @(posedge clock);
         send_pause = 1'b0;
      end
      repeat (150) @(posedge clock);

      $display("covered %0d vertex words, %0d tangent words (%0d flipped, %0d degenerate)",
               words_sent, tangents_seen, flips_seen, degens_seen);
      if (mismatches == 0 && tangent_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("mismatches %0d, left over %0d", mismatches, tangent_queue.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("timeout");
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
design/tvec_pkg.sv
design/tvec_datapath.sv
design/tvec_control.sv
design/triangle_tangent_vector_core.sv
tb/triangle_tangent_vector_core_tb.sv
